FILE: rtl/npfs_pkg.sv
// ----------------------------------------------------------------------------
// npfs_pkg - shared types and codes for the node pool free stack
// Request and response layouts, action and status codes, control groups.
// ----------------------------------------------------------------------------
package npfs_pkg;

	// action codes
	localparam logic [2:0] ACT_ALLOC  = 3'd0;
	localparam logic [2:0] ACT_FREE   = 3'd1;
	localparam logic [2:0] ACT_RDBYTE = 3'd2;
	localparam logic [2:0] ACT_WRBYTE = 3'd3;
	localparam logic [2:0] ACT_RDLINK = 3'd4;
	localparam logic [2:0] ACT_WRLINK = 3'd5;

	// status codes
	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_EMPTY = 2'd1;
	localparam logic [1:0] STAT_RANGE = 2'd2;
	localparam logic [1:0] STAT_FULL  = 2'd3;

	// null node / null link
	localparam logic [6:0] LINK_NULL = 7'h7F;

	// request, last field in the lowest bits
	typedef struct packed {
		logic signed [6:0] link_value;
		logic [7:0]        char_value;
		logic signed [6:0] node_index;
		logic [2:0]        action;
	} req_t;

	// response, last field in the lowest bits
	typedef struct packed {
		logic [1:0]        status;
		logic [6:0]        free_count;
		logic [7:0]        result_char;
		logic signed [6:0] result_node;
	} resp_t;

	localparam int REQ_W  = $bits(req_t);
	localparam int RESP_W = $bits(resp_t);

	// free stack control
	typedef struct packed {
		logic init;
		logic pop_rd;
		logic pop;
		logic push;
	} stack_ctl_t;

	// node store control
	typedef struct packed {
		logic init;
		logic rd;
		logic wr_byte;
		logic wr_link;
	} node_ctl_t;

endpackage

FILE: rtl/npfs_ram.sv
// ----------------------------------------------------------------------------
// npfs_ram - generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module npfs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: rtl/npfs_free_stack.sv
// ----------------------------------------------------------------------------
// npfs_free_stack - stack of free node numbers
// Stack RAM plus depth counter; pop reads the top slot, push writes above it.
// ----------------------------------------------------------------------------
module npfs_free_stack import npfs_pkg::*; #(
	parameter int NODES = 64,
	localparam int AW = $clog2(NODES),
	localparam int DW = $clog2(NODES + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  stack_ctl_t    ctl,
	input  logic [AW-1:0] init_addr,
	input  logic [AW-1:0] push_node,
	output logic [DW-1:0] depth,
	output logic [AW-1:0] top_node
);

	logic [DW-1:0] depth_q;
	logic          we;
	logic [AW-1:0] waddr;
	logic [AW-1:0] wdata;
	logic [AW-1:0] raddr;

	// sweep fills slot j with NODES-1-j so node 0 sits on top
	always_comb begin
		we    = ctl.init || ctl.push;
		waddr = ctl.init ? init_addr : AW'(depth_q);
		wdata = ctl.init ? (AW'(NODES - 1) - init_addr) : push_node;
		raddr = AW'(depth_q - DW'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= DW'(NODES);
		end else if (ctl.pop) begin
			depth_q <= depth_q - DW'(1);
		end else if (ctl.push) begin
			depth_q <= depth_q + DW'(1);
		end
	end

	npfs_ram #(
		.WIDTH (AW),
		.DEPTH (NODES)
	) u_stack_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (ctl.pop_rd),
		.raddr (raddr),
		.rdata (top_node)
	);

	assign depth = depth_q;

endmodule

FILE: rtl/npfs_node_store.sv
// ----------------------------------------------------------------------------
// npfs_node_store - per-node byte and link storage
// Two RAMs sharing one read address and one write address.
// ----------------------------------------------------------------------------
module npfs_node_store import npfs_pkg::*; #(
	parameter int NODES = 64,
	localparam int AW = $clog2(NODES)
) (
	input  logic          clk,
	input  node_ctl_t     ctl,
	input  logic [AW-1:0] init_addr,
	input  logic [AW-1:0] rd_addr,
	input  logic [AW-1:0] wr_addr,
	input  logic [7:0]    char_value,
	input  logic [6:0]    link_value,
	output logic [7:0]    rd_char,
	output logic [6:0]    rd_link
);

	logic          byte_we;
	logic          link_we;
	logic [AW-1:0] waddr;
	logic [7:0]    byte_wdata;
	logic [6:0]    link_wdata;

	// sweep clears bytes and nulls links
	always_comb begin
		byte_we    = ctl.init || ctl.wr_byte;
		link_we    = ctl.init || ctl.wr_link;
		waddr      = ctl.init ? init_addr : wr_addr;
		byte_wdata = ctl.init ? 8'd0 : char_value;
		link_wdata = ctl.init ? LINK_NULL : link_value;
	end

	npfs_ram #(
		.WIDTH (8),
		.DEPTH (NODES)
	) u_byte_ram (
		.clk   (clk),
		.we    (byte_we),
		.waddr (waddr),
		.wdata (byte_wdata),
		.re    (ctl.rd),
		.raddr (rd_addr),
		.rdata (rd_char)
	);

	npfs_ram #(
		.WIDTH (7),
		.DEPTH (NODES)
	) u_link_ram (
		.clk   (clk),
		.we    (link_we),
		.waddr (waddr),
		.wdata (link_wdata),
		.re    (ctl.rd),
		.raddr (rd_addr),
		.rdata (rd_link)
	);

endmodule

FILE: rtl/node_pool_free_stack_top.sv
// ----------------------------------------------------------------------------
// node_pool_free_stack_top - node pool with free-list stack allocator
// Allocate / free nodes and read or write each node's byte and link.
// ----------------------------------------------------------------------------
//
//  channel   direction  payload (lowest bit first)
//  s_*       in         action[2:0] node_index[6:0] char_value[7:0] link_value[6:0]
//  m_*       out        result_node[6:0] result_char[7:0] free_count[6:0] status[1:0]
//
//  Each request is accepted in S_IDLE: the accept edge issues the memory reads
//  (node byte, node link, and the stack top for an allocate); in S_EXEC the
//  result is decided and written back at the done edge. One request is in
//  flight. After reset a clearing pass over every node fills the stack and node
//  RAMs; s_tready stays low for that time.
//  A full response register holds the request in its write-back cycle until
//  m_tready frees the register; s_tready stays low meanwhile.
//
module node_pool_free_stack_top import npfs_pkg::*; #(
	parameter int NODES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // action, node_index, char_value, link_value
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata   // result_node, result_char, free_count, status
);

	localparam int AW = $clog2(NODES);
	localparam int DW = $clog2(NODES + 1);

	typedef enum logic [1:0] {
		S_INIT,
		S_IDLE,
		S_EXEC
	} state_t;

	state_t        state_q;
	logic [AW-1:0] init_q;

	req_t          req;
	logic          accept;
	logic          node_ok;
	logic [AW-1:0] req_node;

	// request held through the write-back cycle
	logic [2:0]    act_s1;
	logic [AW-1:0] node_s1;
	logic          ok_s1;
	logic [7:0]    char_s1;
	logic [6:0]    link_s1;

	logic          done;
	logic          m_valid_q;
	resp_t         resp_q;
	resp_t         resp;

	stack_ctl_t    stk_ctl;
	node_ctl_t     nd_ctl;
	logic [DW-1:0] depth;
	logic [AW-1:0] top_node;
	logic [7:0]    rd_char;
	logic [6:0]    rd_link;
	logic [DW-1:0] depth_next;

	assign req      = req_t'(s_tdata[REQ_W-1:0]);
	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;

	// null (negative) and out-of-range nodes are refused
	assign node_ok  = !req.node_index[6] && ({26'd0, req.node_index[5:0]} < 32'(NODES));
	assign req_node = AW'(req.node_index[5:0]);

	// write-back completes once the response register can take the result
	assign done = (state_q == S_EXEC) && (!m_valid_q || m_tready);

	// state, sweep counter and request registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			init_q  <= '0;
		end else begin
			unique case (state_q)
				S_INIT: begin
					init_q <= init_q + AW'(1);
					if (init_q == AW'(NODES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (done) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_INIT;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_s1  <= req.action;
			node_s1 <= req_node;
			ok_s1   <= node_ok;
			char_s1 <= req.char_value;
			link_s1 <= req.link_value;
		end
	end

	// issue reads on accept; decide, write back and respond on done
	always_comb begin
		stk_ctl        = '0;
		nd_ctl         = '0;
		stk_ctl.init   = (state_q == S_INIT);
		nd_ctl.init    = (state_q == S_INIT);
		stk_ctl.pop_rd = accept && (req.action == ACT_ALLOC);
		nd_ctl.rd      = accept;

		resp             = '0;
		resp.result_node = LINK_NULL;
		resp.status      = STAT_OK;

		if (act_s1 == ACT_ALLOC) begin
			if (depth != '0) begin
				stk_ctl.pop      = done;
				resp.result_node = 7'(top_node);
			end else begin
				resp.status = STAT_EMPTY;
			end
		end else if (act_s1 <= ACT_WRLINK) begin
			if (!ok_s1) begin
				resp.status = STAT_RANGE;
			end else begin
				unique case (act_s1)
					ACT_FREE: begin
						if (depth == DW'(NODES)) begin
							resp.status = STAT_FULL;
						end else begin
							stk_ctl.push = done;
						end
					end
					ACT_RDBYTE: begin
						resp.result_char = rd_char;
					end
					ACT_WRBYTE: begin
						nd_ctl.wr_byte   = done;
						resp.result_char = char_s1;
					end
					ACT_RDLINK: begin
						resp.result_node = rd_link;
					end
					ACT_WRLINK: begin
						nd_ctl.wr_link   = done;
						resp.result_node = link_s1;
					end
					default: begin
					end
				endcase
			end
		end

		// count after this request
		if (stk_ctl.pop) begin
			depth_next = depth - DW'(1);
		end else if (stk_ctl.push) begin
			depth_next = depth + DW'(1);
		end else begin
			depth_next = depth;
		end
		resp.free_count = 7'(depth_next);
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (done) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			resp_q <= resp;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = resp_q;

	npfs_free_stack #(
		.NODES (NODES)
	) u_free_stack (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (stk_ctl),
		.init_addr (init_q),
		.push_node (node_s1),
		.depth     (depth),
		.top_node  (top_node)
	);

	npfs_node_store #(
		.NODES (NODES)
	) u_node_store (
		.clk        (clk),
		.ctl        (nd_ctl),
		.init_addr  (init_q),
		.rd_addr    (req_node),
		.wr_addr    (node_s1),
		.char_value (char_s1),
		.link_value (link_s1),
		.rd_char    (rd_char),
		.rd_link    (rd_link)
	);

	// free count never exceeds the pool
	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth <= DW'(NODES))
		else $error("free count above pool size");

	// an accepted request moves to write-back
	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_EXEC))
		else $error("accepted request did not reach write-back");

	// every completed request leaves a response
	a_done_resp: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> m_valid_q)
		else $error("completed request produced no response");

	// a successful allocate takes exactly one node off the stack
	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		stk_ctl.pop |=> (depth == $past(depth) - DW'(1)))
		else $error("allocate did not decrement free count");

	// no push, pop or completed request while clearing
	a_init_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_INIT) |-> !stk_ctl.push && !stk_ctl.pop && !done)
		else $error("request activity during clearing pass");

endmodule

FILE: tb/sv/node_pool_free_stack_top_tb.sv
// ----------------------------------------------------------------------------
// node_pool_free_stack_top_tb - self-checking bench for the node pool
// Drives allocate, free and node access requests over the slave stream and
// predicts every response from a behavioral copy of the pool and its free
// stack. Responses are compared field by field in arrival order. Both
// streams idle in random bursts except in the final streaming phase.
// ----------------------------------------------------------------------------
module node_pool_free_stack_top_tb;
	import npfs_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int NODES = 64;

	// action codes the block leaves unused
	localparam logic [2:0] ACT_SPARE_6 = 3'd6;
	localparam logic [2:0] ACT_SPARE_7 = 3'd7;

	localparam logic signed [6:0] NODE_NULL = -7'sd1;
	localparam logic signed [6:0] NODE_MOST_NEG = -7'sd64;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;  // action, node_index, char_value, link_value
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;       // result_node, result_char, free_count, status

	// behavioral copy of the pool
	logic [7:0] pool_bytes [NODES];
	logic [6:0] pool_links [NODES];
	logic [5:0] free_slots [NODES];
	logic [6:0] free_depth;

	resp_t pending_resps[$];   // responses still owed by the block, oldest first
	int    held_nodes[$];      // nodes currently allocated by the stimulus
	bit    idle_en = 1'b1;     // random idling on both streams
	int    errors = 0;
	int    m_stall_left = 0;

	node_pool_free_stack_top #(.NODES(NODES)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// generous fixed limit: a correct run needs well under a tenth of this
	initial begin
		#5ms;
		$display("status: fail");
		$finish;
	end

	// Reset state of the pool: stack top holds node 0, every link null.
	task automatic pool_reset();
		for (int j = 0; j < NODES; j++) begin
			pool_bytes[j] = 8'h00;
			pool_links[j] = LINK_NULL;
			free_slots[j] = 6'(NODES - 1 - j);
		end
		free_depth = 7'(NODES);
	endtask

	// Apply one request to the pool copy and return the response it owes.
	function automatic resp_t pool_apply(req_t rq);
		resp_t rs;
		bit    in_range;
		int    n;
		rs.result_node = LINK_NULL;
		rs.result_char = 8'h00;
		rs.status      = STAT_OK;
		in_range = (rq.node_index >= 0) && (int'(rq.node_index) < NODES);
		n = in_range ? int'(rq.node_index) : 0;
		if (rq.action == ACT_ALLOC) begin
			if (free_depth != 0) begin
				free_depth = free_depth - 7'd1;
				rs.result_node = {1'b0, free_slots[free_depth]};
			end else begin
				rs.status = STAT_EMPTY;
			end
		end else if (rq.action <= ACT_WRLINK) begin
			if (!in_range) begin
				rs.status = STAT_RANGE;
			end else begin
				case (rq.action)
					ACT_FREE: begin
						if (free_depth >= 7'(NODES)) begin
							rs.status = STAT_FULL;
						end else begin
							// a double free is pushed again, as the block does
							free_slots[free_depth] = 6'(n);
							free_depth = free_depth + 7'd1;
						end
					end
					ACT_RDBYTE: rs.result_char = pool_bytes[n];
					ACT_WRBYTE: begin
						pool_bytes[n] = rq.char_value;
						rs.result_char = rq.char_value;
					end
					ACT_RDLINK: rs.result_node = pool_links[n];
					default: begin
						// any 7-bit link is stored verbatim
						pool_links[n] = rq.link_value;
						rs.result_node = rq.link_value;
					end
				endcase
			end
		end
		rs.free_count = free_depth;
		return rs;
	endfunction

	// Send one request: maybe idle for a random burst, hold valid until accepted,
	// then predict its response. Valid stays high for a following request.
	task automatic send_req(logic [2:0] act, logic signed [6:0] idx,
		logic [7:0] ch = 8'h00, logic signed [6:0] lnk = NODE_NULL);
		req_t  rq;
		resp_t rs;
		rq.action     = act;
		rq.node_index = idx;
		rq.char_value = ch;
		rq.link_value = lnk;
		if (idle_en && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {7'b0, rq};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		rs = pool_apply(rq);
		pending_resps.push_back(rs);
		if (act == ACT_ALLOC && rs.status == STAT_OK)
			held_nodes.push_back(int'(rs.result_node));
	endtask

	// Node index for a random access: mostly valid, sometimes null or any pattern.
	function automatic logic signed [6:0] pick_node();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return NODE_NULL;
		if (r == 1)
			return 7'($urandom);
		return 7'($urandom_range(0, NODES - 1));
	endfunction

	// Extremes of every field, each action and the full and range refusals.
	task automatic test_directed();
		send_req(ACT_RDBYTE, 7'sd0);
		send_req(ACT_RDBYTE, 7'sd63);
		send_req(ACT_RDLINK, 7'sd63);
		send_req(ACT_WRBYTE, 7'sd0, 8'hFF);
		send_req(ACT_WRBYTE, 7'sd63, 8'hA5);
		send_req(ACT_WRBYTE, 7'sd62, 8'h5A);
		send_req(ACT_RDBYTE, 7'sd0);
		send_req(ACT_RDBYTE, 7'sd63);
		send_req(ACT_WRLINK, 7'sd0, 8'h00, 7'sd63);
		send_req(ACT_WRLINK, 7'sd63, 8'h00, NODE_MOST_NEG);  // names no node
		send_req(ACT_WRLINK, 7'sd1, 8'h00, 7'sd42);
		send_req(ACT_RDLINK, 7'sd0);
		send_req(ACT_RDLINK, 7'sd63);
		send_req(ACT_FREE, 7'sd5);              // stack full
		send_req(ACT_ALLOC, NODE_NULL);         // pops node 0
		send_req(ACT_FREE, 7'sd0);
		send_req(ACT_FREE, NODE_NULL);          // null node refused
		send_req(ACT_FREE, NODE_MOST_NEG);
		send_req(ACT_RDBYTE, NODE_NULL);
		send_req(ACT_WRBYTE, NODE_MOST_NEG, 8'h3C);
		send_req(ACT_RDLINK, -7'sd2);
		send_req(ACT_WRLINK, NODE_NULL, 8'h00, 7'sd7);
		send_req(ACT_SPARE_6, 7'sd3, 8'hFF, 7'sd3);
		send_req(ACT_SPARE_7, NODE_NULL, 8'h81, NODE_MOST_NEG);
		held_nodes.delete();
	endtask

	// Drain the pool past empty, then free every node and one more.
	task automatic test_drain_refill();
		int n;
		repeat (NODES + 2) send_req(ACT_ALLOC, 7'($urandom), 8'($urandom), 7'($urandom));
		while (held_nodes.size() > 0) begin
			n = $urandom_range(0, held_nodes.size() - 1);
			send_req(ACT_FREE, 7'(held_nodes[n]));
			held_nodes.delete(n);
		end
		send_req(ACT_FREE, 7'sd17);
	endtask

	// Mostly well-formed traffic, frees on allocated nodes, with noise mixed in.
	task automatic test_random_traffic(int count);
		int r;
		int n;
		repeat (count) begin
			r = $urandom_range(0, 99);
			if (r < 25 || (r < 45 && held_nodes.size() == 0)) begin
				send_req(ACT_ALLOC, NODE_NULL);
			end else if (r < 45) begin
				n = $urandom_range(0, held_nodes.size() - 1);
				send_req(ACT_FREE, 7'(held_nodes[n]));
				held_nodes.delete(n);
			end else if (r < 55) begin
				send_req(ACT_WRBYTE, pick_node(), 8'($urandom));
			end else if (r < 65) begin
				send_req(ACT_RDBYTE, pick_node());
			end else if (r < 75) begin
				send_req(ACT_WRLINK, pick_node(), 8'($urandom), 7'($urandom));
			end else if (r < 85) begin
				send_req(ACT_RDLINK, pick_node());
			end else if (r < 92) begin
				send_req(3'($urandom_range(1, 5)), 7'($urandom), 8'($urandom),
					7'($urandom));
			end else if (r < 96) begin
				send_req(($urandom_range(0, 1) == 0) ? ACT_SPARE_6 : ACT_SPARE_7,
					7'($urandom), 8'($urandom), 7'($urandom));
			end else begin
				// double free or free of a node never allocated
				send_req(ACT_FREE, 7'($urandom_range(0, NODES - 1)));
			end
		end
	endtask

	// Back-to-back requests with both streams always ready.
	task automatic test_streaming();
		idle_en = 1'b0;
		test_random_traffic(80);
	endtask

	// Sink side: stall in random bursts while idling is on.
	always @(posedge clk) begin
		if (m_stall_left > 0) begin
			m_tready <= 1'b0;
			m_stall_left <= m_stall_left - 1;
		end else if (idle_en && $urandom_range(0, 4) == 0) begin
			m_tready <= 1'b0;
			m_stall_left <= $urandom_range(0, 10);
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Compare each accepted response with the oldest prediction.
	always @(posedge clk) begin : resp_check
		resp_t got;
		resp_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = resp_t'(m_tdata);
			if (pending_resps.size() == 0) begin
				$error("unexpected response %h", m_tdata);
				errors++;
			end else begin
				want = pending_resps.pop_front();
				if (got.result_node !== want.result_node) begin
					$error("result_node: expected %0d, got %0d",
						want.result_node, got.result_node);
					errors++;
				end
				if (got.result_char !== want.result_char) begin
					$error("result_char: expected %h, got %h",
						want.result_char, got.result_char);
					errors++;
				end
				if (got.free_count !== want.free_count) begin
					$error("free_count: expected %0d, got %0d",
						want.free_count, got.free_count);
					errors++;
				end
				if (got.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, got.status);
					errors++;
				end
			end
		end
	end

	initial begin
		pool_reset();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		// the block clears its RAMs first; the handshake waits that out
		test_directed();
		test_drain_refill();
		test_random_traffic(300);
		test_streaming();
		s_tvalid <= 1'b0;
		while (pending_resps.size() > 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0 && pending_resps.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

FILE: filelist.f
rtl/npfs_pkg.sv
rtl/npfs_ram.sv
rtl/npfs_free_stack.sv
rtl/npfs_node_store.sv
rtl/node_pool_free_stack_top.sv
tb/sv/node_pool_free_stack_top_tb.sv
